@@ hw/rtl/byte_accumulator_machine_core_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the byte accumulator machine core.
// ----------------------------------------------------------------------------
`ifndef BYTE_ACCUMULATOR_MACHINE_CORE_TOP_MACROS_SVH
`define BYTE_ACCUMULATOR_MACHINE_CORE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BAM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define BAM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BAM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define BAM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ hw/rtl/bam_pkg.sv @@
// ----------------------------------------------------------------------------
// bam_pkg
// Types, codes and constants of the byte accumulator machine core.
// ----------------------------------------------------------------------------
package bam_pkg;

   localparam int MEM_BYTES = 256;
   localparam int ADDR_W    = 8;
   localparam int DATA_W    = 8;

   // last usable program counter; reaching it halts the machine
   localparam logic [ADDR_W-1:0] PC_LAST = ADDR_W'(MEM_BYTES - 1);

   // item actions
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_START = 2'd2;
   localparam logic [1:0] ACT_STEP  = 2'd3;

   // run status
   localparam logic [1:0] ST_RUN     = 2'd0;
   localparam logic [1:0] ST_DONE    = 2'd1;
   localparam logic [1:0] ST_ILLEGAL = 2'd2;
   localparam logic [1:0] ST_END     = 2'd3;

   // opcodes (ASCII letters)
   localparam logic [7:0] OPC_LOAD      = 8'h47; // G
   localparam logic [7:0] OPC_LOAD_IND  = 8'h67; // g
   localparam logic [7:0] OPC_STORE     = 8'h4F; // O
   localparam logic [7:0] OPC_STORE_IND = 8'h6F; // o
   localparam logic [7:0] OPC_IN        = 8'h52; // R
   localparam logic [7:0] OPC_IN_MEM    = 8'h72; // r
   localparam logic [7:0] OPC_BRZ       = 8'h42; // B
   localparam logic [7:0] OPC_BRZ_IND   = 8'h62; // b
   localparam logic [7:0] OPC_ADDI      = 8'h49; // I
   localparam logic [7:0] OPC_ADD_MEM   = 8'h69; // i
   localparam logic [7:0] OPC_OUT       = 8'h54; // T
   localparam logic [7:0] OPC_OUT_MEM   = 8'h74; // t
   localparam logic [7:0] OPC_SETI      = 8'h53; // S
   localparam logic [7:0] OPC_XOR       = 8'h73; // s
   localparam logic [7:0] OPC_ADD       = 8'h41; // A
   localparam logic [7:0] OPC_ADD_IND   = 8'h61; // a
   localparam logic [7:0] OPC_HALT      = 8'h44; // D

   // shared unit operations
   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_XOR = 1'b1;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
   } mem_req_type;

   typedef struct packed {
      logic              op;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [DATA_W:0]   sum;
      logic [DATA_W-1:0] result;
   } alu_rsp_type;

endpackage

@@ hw/rtl/bam_mem.sv @@
// ----------------------------------------------------------------------------
// bam_mem
// Single-port code/data RAM, registered read data.
// ----------------------------------------------------------------------------
module bam_mem (
   input  logic                       clock,
   input  bam_pkg::mem_req_type       req,
   output logic [bam_pkg::DATA_W-1:0] rdata
);
   import bam_pkg::*;

   logic [DATA_W-1:0] mem_array [MEM_BYTES];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem_array[req.addr] <= req.wdata;
      end
      rd_data_ff <= mem_array[req.addr];
   end

   assign rdata = rd_data_ff;

endmodule

@@ hw/rtl/bam_alu.sv @@
// ----------------------------------------------------------------------------
// bam_alu
// Shared 8-bit add/xor unit used by the sequencer for pc increments and data operations.
// ----------------------------------------------------------------------------
module bam_alu (
   input  bam_pkg::alu_req_type req,
   output bam_pkg::alu_rsp_type rsp
);
   import bam_pkg::*;

   logic [DATA_W:0] sum;

   assign sum = {1'b0, req.a} + {1'b0, req.b};

   always_comb begin
      rsp.sum    = sum;
      rsp.result = (req.op == ALU_XOR) ? (req.a ^ req.b) : sum[DATA_W-1:0];
   end

endmodule

@@ hw/rtl/bam_seq.sv @@
// ----------------------------------------------------------------------------
// bam_seq
// Sequencer: memory clear sweep, item dispatch, fetch/execute of one step.
// ----------------------------------------------------------------------------
`include "byte_accumulator_machine_core_top_macros.svh"

module bam_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_action,
   input  logic [7:0]                 req_address,
   input  logic [7:0]                 req_data,
   input  logic [7:0]                 req_in_char,
   input  logic                       req_in_eof,
   output bam_pkg::mem_req_type       mem_req,
   input  logic [bam_pkg::DATA_W-1:0] mem_rdata,
   output bam_pkg::alu_req_type       alu_req,
   input  bam_pkg::alu_rsp_type       alu_rsp,
   output logic                       rsp_strobe,
   output logic [7:0]                 rsp_read_data,
   output logic                       rsp_out_valid,
   output logic [7:0]                 rsp_out_char,
   output logic                       rsp_in_used,
   output logic [1:0]                 rsp_run_status,
   output logic [7:0]                 rsp_program_counter,
   output logic [7:0]                 rsp_accumulator_value
);
   import bam_pkg::*;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_EXEC   = 4'd2;
   localparam logic [3:0] S_RDWAIT = 4'd3;
   localparam logic [3:0] S_FOP    = 4'd4;
   localparam logic [3:0] S_FIMM   = 4'd5;
   localparam logic [3:0] S_MEM1   = 4'd6;
   localparam logic [3:0] S_MEM2   = 4'd7;
   localparam logic [3:0] S_NEXT   = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [1:0]        action_ff, action_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [DATA_W-1:0] inval_ff, inval_in;
   logic [DATA_W-1:0] op_ff, op_in;
   logic [DATA_W-1:0] imm_ff, imm_in;
   logic [ADDR_W-1:0] target_ff, target_in;
   logic              take_ff, take_in;
   logic [ADDR_W-1:0] pc_ff, pc_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [1:0]        status_ff, status_in;
   logic [DATA_W-1:0] rd_data_ff, rd_data_in;
   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_char_ff, out_char_in;
   logic              in_used_ff, in_used_in;
   logic              strobe_ff, strobe_in;
   logic [ADDR_W:0]   next_pc;
   logic              acc_zero;

   assign acc_zero = (acc_ff == '0);
   assign busy     = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      action_in    = action_ff;
      addr_in      = addr_ff;
      data_in      = data_ff;
      inval_in     = inval_ff;
      op_in        = op_ff;
      imm_in       = imm_ff;
      target_in    = target_ff;
      take_in      = take_ff;
      pc_in        = pc_ff;
      acc_in       = acc_ff;
      status_in    = status_ff;
      rd_data_in   = rd_data_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      in_used_in   = in_used_ff;
      strobe_in    = 1'b0;
      next_pc      = '0;
      mem_req.we    = 1'b0;
      mem_req.addr  = pc_ff;
      mem_req.wdata = acc_ff;
      alu_req.op    = ALU_ADD;
      alu_req.a     = pc_ff;
      alu_req.b     = 8'd1;

      case (state_ff)
         S_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = clr_ff;
            mem_req.wdata = '0;
            clr_in        = clr_ff + 1'b1;
            if (clr_ff == PC_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               action_in    = req_action;
               addr_in      = req_address;
               data_in      = req_data;
               inval_in     = req_in_eof ? 8'hFF : req_in_char;
               rd_data_in   = '0;
               out_valid_in = 1'b0;
               out_char_in  = '0;
               in_used_in   = 1'b0;
               take_in      = 1'b0;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            case (action_ff)
               ACT_WRITE: begin
                  mem_req.we    = 1'b1;
                  mem_req.addr  = addr_ff;
                  mem_req.wdata = data_ff;
                  strobe_in     = 1'b1;
                  state_in      = S_IDLE;
               end
               ACT_READ: begin
                  mem_req.addr = addr_ff;
                  state_in     = S_RDWAIT;
               end
               ACT_START: begin
                  pc_in     = '0;
                  acc_in    = '0;
                  status_in = ST_RUN;
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end
               default: begin
                  if (status_ff != ST_RUN) begin
                     strobe_in = 1'b1;
                     state_in  = S_IDLE;
                  end else if (pc_ff == PC_LAST) begin
                     status_in = ST_END;
                     strobe_in = 1'b1;
                     state_in  = S_IDLE;
                  end else begin
                     mem_req.addr = pc_ff;
                     state_in     = S_FOP;
                  end
               end
            endcase
         end
         S_RDWAIT: begin
            rd_data_in = mem_rdata;
            strobe_in  = 1'b1;
            state_in   = S_IDLE;
         end
         S_FOP: begin
            // opcode in hand, fetch immediate at pc+1
            op_in        = mem_rdata;
            alu_req.a    = pc_ff;
            alu_req.b    = 8'd1;
            mem_req.addr = alu_rsp.result;
            state_in     = S_FIMM;
         end
         S_FIMM: begin
            imm_in   = mem_rdata;
            state_in = S_NEXT;
            case (op_ff)
               OPC_LOAD, OPC_ADD, OPC_XOR, OPC_OUT_MEM, OPC_BRZ_IND,
               OPC_ADD_MEM, OPC_LOAD_IND, OPC_ADD_IND, OPC_STORE_IND: begin
                  mem_req.addr = mem_rdata;
                  state_in     = S_MEM1;
               end
               OPC_STORE: begin
                  mem_req.we    = 1'b1;
                  mem_req.addr  = mem_rdata;
                  mem_req.wdata = acc_ff;
               end
               OPC_IN: begin
                  acc_in     = inval_ff;
                  in_used_in = 1'b1;
               end
               OPC_IN_MEM: begin
                  mem_req.we    = 1'b1;
                  mem_req.addr  = mem_rdata;
                  mem_req.wdata = inval_ff;
                  in_used_in    = 1'b1;
               end
               OPC_BRZ: begin
                  if (acc_zero) begin
                     take_in   = 1'b1;
                     target_in = mem_rdata;
                  end
               end
               OPC_ADDI: begin
                  alu_req.a = acc_ff;
                  alu_req.b = mem_rdata;
                  acc_in    = alu_rsp.result;
               end
               OPC_OUT: begin
                  out_valid_in = 1'b1;
                  out_char_in  = acc_ff;
               end
               OPC_SETI: begin
                  acc_in = mem_rdata;
               end
               OPC_HALT: begin
                  status_in = ST_DONE;
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end
               default: begin
                  status_in = ST_ILLEGAL;
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end
            endcase
         end
         S_MEM1: begin
            // mem_rdata = M[imm]
            state_in = S_NEXT;
            case (op_ff)
               OPC_LOAD: begin
                  acc_in = mem_rdata;
               end
               OPC_ADD: begin
                  alu_req.a = acc_ff;
                  alu_req.b = mem_rdata;
                  acc_in    = alu_rsp.result;
               end
               OPC_XOR: begin
                  alu_req.op = ALU_XOR;
                  alu_req.a  = acc_ff;
                  alu_req.b  = mem_rdata;
                  acc_in     = alu_rsp.result;
               end
               OPC_OUT_MEM: begin
                  out_valid_in = 1'b1;
                  out_char_in  = mem_rdata;
               end
               OPC_BRZ_IND: begin
                  if (acc_zero) begin
                     take_in   = 1'b1;
                     target_in = mem_rdata;
                  end
               end
               OPC_ADD_MEM: begin
                  alu_req.a     = mem_rdata;
                  alu_req.b     = acc_ff;
                  mem_req.we    = 1'b1;
                  mem_req.addr  = imm_ff;
                  mem_req.wdata = alu_rsp.result;
               end
               OPC_LOAD_IND, OPC_ADD_IND: begin
                  mem_req.addr = mem_rdata;
                  state_in     = S_MEM2;
               end
               OPC_STORE_IND: begin
                  mem_req.we    = 1'b1;
                  mem_req.addr  = mem_rdata;
                  mem_req.wdata = acc_ff;
               end
               default: begin
               end
            endcase
         end
         S_MEM2: begin
            // mem_rdata = M[M[imm]]
            state_in = S_NEXT;
            if (op_ff == OPC_ADD_IND) begin
               alu_req.a = acc_ff;
               alu_req.b = mem_rdata;
               acc_in    = alu_rsp.result;
            end else begin
               acc_in = mem_rdata;
            end
         end
         S_NEXT: begin
            alu_req.a = pc_ff;
            alu_req.b = 8'd2;
            next_pc   = take_ff ? {1'b0, target_ff} : alu_rsp.sum;
            if (next_pc >= {1'b0, PC_LAST}) begin
               status_in = ST_END;
               pc_in     = PC_LAST;
            end else begin
               pc_in = next_pc[ADDR_W-1:0];
            end
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         pc_ff     <= '0;
         acc_ff    <= '0;
         status_ff <= ST_RUN;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         pc_ff     <= pc_in;
         acc_ff    <= acc_in;
         status_ff <= status_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff    <= action_in;
      addr_ff      <= addr_in;
      data_ff      <= data_in;
      inval_ff     <= inval_in;
      op_ff        <= op_in;
      imm_ff       <= imm_in;
      target_ff    <= target_in;
      take_ff      <= take_in;
      rd_data_ff   <= rd_data_in;
      out_valid_ff <= out_valid_in;
      out_char_ff  <= out_char_in;
      in_used_ff   <= in_used_in;
   end

   assign rsp_strobe            = strobe_ff;
   assign rsp_read_data         = rd_data_ff;
   assign rsp_out_valid         = out_valid_ff;
   assign rsp_out_char          = out_char_ff;
   assign rsp_in_used           = in_used_ff;
   assign rsp_run_status        = status_ff;
   assign rsp_program_counter   = pc_ff;
   assign rsp_accumulator_value = acc_ff;

   `BAM_ASSERT_IMP(a_strobe_idle, clock, reset, strobe_ff, state_ff == S_IDLE, "result outside idle")
   `BAM_ASSERT_NXT(a_accept_exec, clock, reset, start && !busy, state_ff == S_EXEC, "accept lost")
   `BAM_ASSERT_IMP(a_clear_quiet, clock, reset, state_ff == S_CLEAR, !strobe_ff, "result during clear")
   `BAM_ASSERT_IMP(a_io_excl, clock, reset, strobe_ff, !(out_valid_ff && in_used_ff), "in and out together")
   `BAM_ASSERT_IMP(a_out_halt, clock, reset, strobe_ff && out_valid_ff, status_ff != ST_DONE && status_ff != ST_ILLEGAL, "output on halt")

endmodule

@@ hw/rtl/byte_accumulator_machine_core_top.sv @@
// ----------------------------------------------------------------------------
// byte_accumulator_machine_core_top
// 8-bit accumulator machine with a 256-byte shared code/data RAM.
// ----------------------------------------------------------------------------
//
// Channel   Ports                        Handshake
// --------  ---------------------------  ---------------------------------
// request   start, busy, req_*           item taken when start && !busy
// response  rsp_strobe, rsp_*            one cycle per item, no backpressure
//
// A step runs opcode fetch, immediate fetch, decode, up to two dependent data
// reads, pc update and result, in that order. A step on a halted machine only
// reports its state; a halt by D or an illegal opcode ends after decode, with
// no pc update. The single RAM port serializes the fetches and dependent reads.
// Reset: a clearing pass writes zero to all 256 bytes, busy high.
// Stalls: none on the output; the next item can be taken while the strobe is up.
// Every item returns exactly one result.
//
module byte_accumulator_machine_core_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_action,
   input  logic [7:0] req_address,
   input  logic [7:0] req_data,
   input  logic [7:0] req_in_char,
   input  logic       req_in_eof,
   output logic       rsp_strobe,
   output logic [7:0] rsp_read_data,
   output logic       rsp_out_valid,
   output logic [7:0] rsp_out_char,
   output logic       rsp_in_used,
   output logic [1:0] rsp_run_status,
   output logic [7:0] rsp_program_counter,
   output logic [7:0] rsp_accumulator_value
);
   import bam_pkg::*;

   mem_req_type       mem_req;
   logic [DATA_W-1:0] mem_rdata;
   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;

   // sequencer owns all machine state and the result registers
   bam_seq u_seq (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_action            (req_action),
      .req_address           (req_address),
      .req_data              (req_data),
      .req_in_char           (req_in_char),
      .req_in_eof            (req_in_eof),
      .mem_req               (mem_req),
      .mem_rdata             (mem_rdata),
      .alu_req               (alu_req),
      .alu_rsp               (alu_rsp),
      .rsp_strobe            (rsp_strobe),
      .rsp_read_data         (rsp_read_data),
      .rsp_out_valid         (rsp_out_valid),
      .rsp_out_char          (rsp_out_char),
      .rsp_in_used           (rsp_in_used),
      .rsp_run_status        (rsp_run_status),
      .rsp_program_counter   (rsp_program_counter),
      .rsp_accumulator_value (rsp_accumulator_value)
   );

   // one adder/xor shared by pc increments and data operations
   bam_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // single-port RAM, read data registered and valid in the cycle after the address
   bam_mem u_mem (
      .clock (clock),
      .req   (mem_req),
      .rdata (mem_rdata)
   );

endmodule

@@ tb/byte_accumulator_machine_core_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_accumulator_machine_core_top_tb
// Drives memory writes, reads, starts and instruction steps into the machine
// and checks every result, field by field, against an in-bench copy of the
// machine's memory, program counter, accumulator and run status.
// ----------------------------------------------------------------------------
module byte_accumulator_machine_core_top_tb;
   import bam_pkg::*;

   localparam int         ITEM_TARGET = 1950;
   localparam int         IDLE_LIMIT  = 1000;  // covers the reset clear plus long gaps
   localparam int         TAIL_CYCLES = 20;
   localparam logic [7:0] DATA_AREA   = 8'h80; // operands and pointers live here
   localparam logic [7:0] BAD_OPCODE  = 8'h00;

   // legal opcodes drawn for random programs; halt is in the set on purpose
   localparam logic [7:0] OPCODE_SET [17] = '{
      OPC_LOAD, OPC_LOAD_IND, OPC_STORE, OPC_STORE_IND, OPC_IN, OPC_IN_MEM,
      OPC_BRZ, OPC_BRZ_IND, OPC_ADDI, OPC_ADD_MEM, OPC_OUT, OPC_OUT_MEM,
      OPC_SETI, OPC_XOR, OPC_ADD, OPC_ADD_IND, OPC_HALT};

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] address;
      logic [7:0] data;
      logic [7:0] in_char;
      logic       in_eof;
      logic [7:0] gap;    // idle cycles before this item is offered
      logic       drain;  // hold this item until every result is back
   } machine_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       out_valid;
      logic [7:0] out_char;
      logic       in_used;
      logic [1:0] run_status;
      logic [7:0] program_counter;
      logic [7:0] accumulator_value;
   } machine_result_type;

   // DUT ports; every input is known from time zero
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_action  = ACT_READ;
   logic [7:0] req_address = 8'h00;
   logic [7:0] req_data    = 8'h00;
   logic [7:0] req_in_char = 8'h00;
   logic       req_in_eof  = 1'b0;
   logic       rsp_strobe;
   logic [7:0] rsp_read_data;
   logic       rsp_out_valid;
   logic [7:0] rsp_out_char;
   logic       rsp_in_used;
   logic [1:0] rsp_run_status;
   logic [7:0] rsp_program_counter;
   logic [7:0] rsp_accumulator_value;

   // machine state as the bench sees it
   logic [7:0] mem_image [MEM_BYTES] = '{default: 8'h00};
   logic [7:0] pc_now  = 8'h00;
   logic [7:0] acc_now = 8'h00;
   logic [1:0] run_now = ST_RUN;

   machine_item_type   machine_items[$];    // stimulus not yet offered
   machine_result_type pending_results[$];  // expectations, oldest first

   // driver bookkeeping
   machine_item_type cur_item;
   logic             drive_start;
   logic             gap_armed = 1'b0;
   int               gap_left = 0;
   int               issued_count = 0;
   int               accepted_count = 0;
   bit               quiet_run = 1'b0;
   int               stim_total = 0;

   // run statistics
   int error_count = 0;
   int idle_cycles = 0;
   int n_checked = 0;
   int n_writes = 0, n_reads = 0, n_starts = 0, n_exec = 0;
   int n_emit = 0, n_input = 0;
   int halt_seen [4] = '{default: 0};

   byte_accumulator_machine_core_top DUT (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_action            (req_action),
      .req_address           (req_address),
      .req_data              (req_data),
      .req_in_char           (req_in_char),
      .req_in_eof            (req_in_eof),
      .rsp_strobe            (rsp_strobe),
      .rsp_read_data         (rsp_read_data),
      .rsp_out_valid         (rsp_out_valid),
      .rsp_out_char          (rsp_out_char),
      .rsp_in_used           (rsp_in_used),
      .rsp_run_status        (rsp_run_status),
      .rsp_program_counter   (rsp_program_counter),
      .rsp_accumulator_value (rsp_accumulator_value)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Applies one accepted item to the bench's machine state and returns the
   // result the core must report for it.
   function automatic machine_result_type next_machine_result(
      logic [1:0] act, logic [7:0] adr, logic [7:0] dat, logic [7:0] chr, logic eof);
      machine_result_type r;
      logic [7:0]         opc, imm, ptr, inval;
      logic [8:0]         nxt;
      logic               stopped;
      r = '0;
      case (act)
         ACT_WRITE: begin
            mem_image[adr] = dat;
            n_writes++;
         end
         ACT_READ: begin
            r.read_data = mem_image[adr];
            n_reads++;
         end
         ACT_START: begin
            pc_now  = 8'h00;
            acc_now = 8'h00;
            run_now = ST_RUN;
            n_starts++;
         end
         ACT_STEP: begin
            // a halted machine ignores steps and just reports its state
            if (run_now == ST_RUN && pc_now == PC_LAST) begin
               run_now = ST_END;
            end else if (run_now == ST_RUN) begin
               n_exec++;
               opc     = mem_image[pc_now];
               imm     = mem_image[pc_now + 8'd1];
               ptr     = mem_image[imm];       // every operand read precedes the write
               nxt     = {1'b0, pc_now} + 9'd2;
               inval   = eof ? 8'hFF : chr;
               stopped = 1'b0;
               case (opc)
                  OPC_LOAD:      acc_now = ptr;
                  OPC_LOAD_IND:  acc_now = mem_image[ptr];
                  OPC_STORE:     mem_image[imm] = acc_now;
                  OPC_STORE_IND: mem_image[ptr] = acc_now;
                  OPC_IN: begin
                     acc_now   = inval;
                     r.in_used = 1'b1;
                  end
                  OPC_IN_MEM: begin
                     mem_image[imm] = inval;
                     r.in_used      = 1'b1;
                  end
                  OPC_BRZ:       if (acc_now == 8'h00) nxt = {1'b0, imm};
                  OPC_BRZ_IND:   if (acc_now == 8'h00) nxt = {1'b0, ptr};
                  OPC_ADDI:      acc_now = acc_now + imm;
                  OPC_ADD_MEM:   mem_image[imm] = ptr + acc_now;
                  OPC_OUT: begin
                     r.out_valid = 1'b1;
                     r.out_char  = acc_now;
                  end
                  OPC_OUT_MEM: begin
                     r.out_valid = 1'b1;
                     r.out_char  = ptr;
                  end
                  OPC_SETI:      acc_now = imm;
                  OPC_XOR:       acc_now = acc_now ^ ptr;
                  OPC_ADD:       acc_now = acc_now + ptr;
                  OPC_ADD_IND:   acc_now = acc_now + mem_image[ptr];
                  OPC_HALT: begin
                     run_now = ST_DONE;
                     stopped = 1'b1;
                  end
                  default: begin
                     run_now = ST_ILLEGAL;
                     stopped = 1'b1;
                  end
               endcase
               // halt and illegal keep pc on the opcode; otherwise saturate at the end
               if (!stopped && nxt >= {1'b0, PC_LAST}) begin
                  run_now = ST_END;
                  pc_now  = PC_LAST;
               end else if (!stopped) begin
                  pc_now = nxt[7:0];
               end
               if (run_now != ST_RUN) halt_seen[run_now]++;
               if (r.out_valid) n_emit++;
               if (r.in_used) n_input++;
            end
         end
      endcase
      r.run_status        = run_now;
      r.program_counter   = pc_now;
      r.accumulator_value = acc_now;
      return r;
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // Appends one item; the gap before it follows the current idling mode.
   task automatic queue_item(logic [1:0] act, logic [7:0] adr, logic [7:0] dat,
                             logic [7:0] chr, logic eof, logic drain);
      machine_item_type it;
      int               pick;
      pick = $urandom_range(0, 19);
      it.action  = act;
      it.address = adr;
      it.data    = dat;
      it.in_char = chr;
      it.in_eof  = eof;
      it.drain   = drain;
      if (quiet_run || pick > 5) it.gap = 8'd0;
      else if (pick == 0) it.gap = 8'($urandom_range(20, 60));
      else it.gap = 8'($urandom_range(1, 3));
      machine_items.push_back(it);
      stim_total++;
   endtask

   // ------------------------------------------------------------------------
   // Driver. Inputs move on the falling edge. An item stays on the bus until
   // the monitor has counted its acceptance; only then is the next one
   // offered, after its gap and, for a drain item, after all results are in.
   // start gets exactly one nonblocking update per falling edge.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      drive_start = start;
      if (reset) begin
         drive_start = 1'b0;
      end else if (!start || issued_count == accepted_count) begin
         drive_start = 1'b0;
         if (machine_items.size() != 0) begin
            if (!gap_armed) begin
               gap_left  = machine_items[0].gap;
               gap_armed = 1'b1;
            end
            if (gap_left != 0) begin
               gap_left--;
            end else if (!(machine_items[0].drain && pending_results.size() != 0)) begin
               cur_item    = machine_items.pop_front();
               req_action  <= cur_item.action;
               req_address <= cur_item.address;
               req_data    <= cur_item.data;
               req_in_char <= cur_item.in_char;
               req_in_eof  <= cur_item.in_eof;
               issued_count++;
               gap_armed   = 1'b0;
               drive_start = 1'b1;
            end
         end
      end
      start <= drive_start;
   end

   // ------------------------------------------------------------------------
   // Monitor. On each rising edge: check a strobed result against the oldest
   // expectation first, then predict for an item taken on this same edge
   // (the core may take the next item while a strobe is up). The watchdog
   // counts edges on which neither side moved anything.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      machine_result_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               $error("result strobed with no item outstanding");
               error_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("read_data", want.read_data, rsp_read_data);
               check_field("out_valid", 8'(want.out_valid), 8'(rsp_out_valid));
               check_field("out_char", want.out_char, rsp_out_char);
               check_field("in_used", 8'(want.in_used), 8'(rsp_in_used));
               check_field("run_status", 8'(want.run_status), 8'(rsp_run_status));
               check_field("program_counter", want.program_counter, rsp_program_counter);
               check_field("accumulator_value", want.accumulator_value,
                           rsp_accumulator_value);
               n_checked++;
            end
         end
         if (start && !busy) begin
            pending_results.push_back(next_machine_result(req_action, req_address,
               req_data, req_in_char, req_in_eof));
            accepted_count++;
         end
      end
      if (rsp_strobe || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
         $display("[byte_accumulator_machine_core_top] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run.
   // ------------------------------------------------------------------------
   initial begin
      int         n_instr, k;
      logic [7:0] opc, imm;

      // --- directed: memory extremes, every action, each halt kind ---
      queue_item(ACT_WRITE, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
      queue_item(ACT_READ, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0);
      queue_item(ACT_READ, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0);   // cleared at reset
      queue_item(ACT_WRITE, 8'h00, BAD_OPCODE, 8'h00, 1'b0, 1'b0);
      queue_item(ACT_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);   // illegal opcode halt
      queue_item(ACT_STEP, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);   // step while halted
      queue_item(ACT_START, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);  // waits for all results
      queue_item(ACT_WRITE, 8'h00, OPC_HALT, 8'h00, 1'b0, 1'b0);
      queue_item(ACT_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);   // halt opcode
      queue_item(ACT_START, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
      queue_item(ACT_WRITE, 8'h00, OPC_BRZ, 8'h00, 1'b0, 1'b0);
      queue_item(ACT_WRITE, 8'h01, PC_LAST, 8'h00, 1'b0, 1'b0);
      queue_item(ACT_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);   // branch onto the last byte
      queue_item(ACT_START, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
      queue_item(ACT_WRITE, 8'h01, 8'd253, 8'h00, 1'b0, 1'b0);
      queue_item(ACT_WRITE, 8'd253, OPC_IN, 8'h00, 1'b0, 1'b0);
      queue_item(ACT_WRITE, 8'd254, 8'h00, 8'h00, 1'b0, 1'b0);
      queue_item(ACT_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);   // branch to 253
      queue_item(ACT_STEP, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0);   // eof read, runs off the end
      queue_item(ACT_START, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
      queue_item(ACT_WRITE, 8'h00, OPC_OUT, 8'h00, 1'b0, 1'b0);
      queue_item(ACT_STEP, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0);

      // --- random programs: load, start, step, with reads and noise mixed in ---
      for (int ep = 0; stim_total < ITEM_TARGET; ep++) begin
         quiet_run = ($urandom_range(0, 3) == 0);
         n_instr   = $urandom_range(2, 10);
         for (k = 0; k < n_instr; k++) begin
            if ($urandom_range(0, 9) == 0) opc = 8'($urandom);
            else opc = OPCODE_SET[$urandom_range(0, 16)];
            // operands: anywhere, the data area, inside the program, or near the end
            case ($urandom_range(0, 3))
               0:       imm = 8'($urandom);
               1:       imm = DATA_AREA + 8'($urandom_range(0, 15));
               2:       imm = 8'($urandom_range(0, 2 * n_instr));
               default: imm = 8'($urandom_range(248, 255));
            endcase
            queue_item(ACT_WRITE, 8'(2 * k), opc, 8'($urandom), 1'($urandom), 1'b0);
            queue_item(ACT_WRITE, 8'(2 * k + 1), imm, 8'($urandom), 1'($urandom), 1'b0);
         end
         repeat ($urandom_range(0, 4))
            queue_item(ACT_WRITE, DATA_AREA + 8'($urandom_range(0, 15)), 8'($urandom),
                       8'($urandom), 1'($urandom), 1'b0);
         queue_item(ACT_START, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                    ep % 12 == 0);
         repeat ($urandom_range(n_instr, n_instr + 4)) begin
            if ($urandom_range(0, 7) == 0)
               queue_item(ACT_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                          1'($urandom), 1'b0);
            queue_item(ACT_STEP, 8'($urandom), 8'($urandom), 8'($urandom),
                       $urandom_range(0, 7) == 0, 1'b0);
         end
         // noise: any action, any field
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 6))
               queue_item(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          1'($urandom), 1'b0);
      end

      // single reset at start of run; the core then clears its RAM on its own
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (machine_items.size() != 0 || issued_count != accepted_count)
         @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("run covered %0d writes, %0d reads, %0d starts, %0d executed steps",
               n_writes, n_reads, n_starts, n_exec);
      $display("%0d outputs, %0d inputs; halts: %0d opcode D, %0d illegal, %0d end; %0d checked",
               n_emit, n_input, halt_seen[ST_DONE], halt_seen[ST_ILLEGAL],
               halt_seen[ST_END], n_checked);
      if (error_count == 0) begin
         $display("[byte_accumulator_machine_core_top] OK");
      end else begin
         $display("[byte_accumulator_machine_core_top] ERROR");
      end
      $finish;
   end

endmodule
